// ===== sv/rbcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbcc_pkg;

  // Default table sizes
  localparam int N_BINS_DEF     = 16;
  localparam int NUM_RANGES_DEF = 32;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Operation codes
  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_ADD    = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Bin kinds
  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_ILLEGAL = 2'd1,
    KIND_IGNORE  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [3:0] {
    STAT_OK        = 4'd0,
    STAT_REG_HIT   = 4'd1,
    STAT_IGN_HIT   = 4'd2,
    STAT_ILL_HIT   = 4'd3,
    STAT_UNMAPPED  = 4'd4,
    STAT_DUP_BIN   = 4'd5,
    STAT_BAD_RANGE = 4'd6,
    STAT_OVERLAP   = 4'd7,
    STAT_FULL      = 4'd8
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CNT_RD,
    S_CNT_WR
  } state_t;

  // One entry of the range table
  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic [3:0]  owner;
  } range_ent_t;

endpackage

`default_nettype wire

// ===== sv/range_bin_coverage_counter.sv =====
// Sequence: define, clear, and add range or sample on an empty table finish in the execute
//   state; otherwise add range and sample scan the stored ranges (an overlap ends the scan
//   early), and a sample that hits a bin then reads and writes back the bin count; done is registered.
// Throughput: one item at a time; the next item may be taken in the done cycle. The range
//   scan reads one table entry per cycle through one comparator pair.
// Reset: synchronous rst empties both tables and clears all counts; no clearing pass.
// done is a single-cycle strobe; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module range_bin_coverage_counter import rbcc_pkg::*; #(
  parameter int N_BINS     = N_BINS_DEF,
  parameter int NUM_RANGES = NUM_RANGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] value,
  input  wire logic [63:0] upper_bound,
  input  wire logic [3:0]  bin_id,
  input  wire logic [1:0]  bin_kind,
  output logic             done,
  output logic [3:0]       status,
  output logic [3:0]       hit_bin,
  output logic [31:0]      hit_count,
  output logic [31:0]      sample_total,
  output logic [4:0]       regular_defined,
  output logic [4:0]       regular_hit
);

  localparam int BIN_W  = (N_BINS > 1) ? $clog2(N_BINS) : 1;
  localparam int RIDX_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int FILL_W = $clog2(NUM_RANGES + 1);
  localparam int CNT_W  = $clog2(N_BINS + 1);

  state_t state, state_next;

  // Latched item
  op_t         op_r;
  logic [63:0] value_r;
  logic [63:0] upper_r;
  logic [3:0]  id_r;
  logic [1:0]  kind_r;

  // Table and bin state
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] issue_idx;
  logic              rd_valid;
  logic              bin_present [N_BINS];
  kind_t             bin_type    [N_BINS];
  logic              bin_nz      [N_BINS];
  logic [31:0]       cnt_mem     [N_BINS];
  logic [31:0]       cnt_q;
  logic [31:0]       samples;
  logic [CNT_W-1:0]  ndef;
  logic [CNT_W-1:0]  nhit;

  // Sample search result
  logic        found_reg;
  logic [3:0]  hit_owner;

  // Result register
  status_t     status_r;
  logic [3:0]  hit_bin_r;
  logic [31:0] hit_count_r;

  // Range table port
  range_ent_t ent;
  range_ent_t wr_ent;
  logic       tab_rd_en;
  logic       tab_wr_en;

  // Shared comparator pair
  logic [63:0] cmp_a0, cmp_b0, cmp_a1, cmp_b1;
  logic        le0, le1;

  // Decode helpers
  logic             accept;
  logic [BIN_W-1:0] idb;
  logic [BIN_W-1:0] ent_bin;
  logic [BIN_W-1:0] hb;
  logic             id_ok;
  logic             kind_ok;
  logic             add_bad;
  logic             all_issued;
  logic             scan_end;
  logic             in_range;
  logic             hit_any;
  logic             hit_nonreg;
  logic             hit_reg;
  logic             overlap;
  logic             tab_full;
  logic [31:0]      cnt_cur;
  logic [31:0]      cnt_inc;

  // Control outputs of the sequencer
  logic        fin;
  status_t     fin_status;
  logic [3:0]  fin_bin;
  logic [31:0] fin_count;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  rbcc_range_tab #(
    .DEPTH  (NUM_RANGES),
    .ADDR_W (RIDX_W)
  ) u_tab (
    .clk     (clk),
    .wr_en   (tab_wr_en),
    .wr_addr (fill[RIDX_W-1:0]),
    .wr_data (wr_ent),
    .rd_en   (tab_rd_en),
    .rd_addr (issue_idx[RIDX_W-1:0]),
    .rd_data (ent)
  );

  assign wr_ent = '{low: value_r, high: upper_r, owner: id_r};

  // Comparator operand select
  always_comb begin
    cmp_a0 = value_r;
    cmp_b0 = upper_r;
    cmp_a1 = value_r;
    cmp_b1 = upper_r;
    if (state == S_SCAN) begin
      if (op_r == OP_ADD) begin
        cmp_a0 = value_r;
        cmp_b0 = ent.high;
        cmp_a1 = ent.low;
        cmp_b1 = upper_r;
      end else begin
        cmp_a0 = ent.low;
        cmp_b0 = value_r;
        cmp_a1 = value_r;
        cmp_b1 = ent.high;
      end
    end
  end

  assign le0 = (cmp_a0 <= cmp_b0);
  assign le1 = (cmp_a1 <= cmp_b1);

  // Decode of the current item and scan entry
  assign idb        = BIN_W'(id_r);
  assign ent_bin    = BIN_W'(ent.owner);
  assign hb         = BIN_W'(hit_owner);
  assign id_ok      = (32'(id_r) < N_BINS);
  assign kind_ok    = (kind_r == KIND_REGULAR) || (kind_r == KIND_ILLEGAL) ||
                      (kind_r == KIND_IGNORE);
  assign add_bad    = !id_ok || !bin_present[idb] || !le0;
  assign all_issued = (issue_idx == fill);
  assign scan_end   = rd_valid && all_issued;
  assign in_range   = le0 && le1;
  assign hit_any    = rd_valid && in_range && bin_present[ent_bin];
  assign hit_nonreg = hit_any && (bin_type[ent_bin] != KIND_REGULAR);
  assign hit_reg    = hit_any && (bin_type[ent_bin] == KIND_REGULAR);
  assign overlap    = rd_valid && in_range && (ent.owner != id_r);
  assign tab_full   = (fill == FILL_W'(NUM_RANGES));
  assign cnt_cur    = bin_nz[hb] ? cnt_q : 32'd0;
  assign cnt_inc    = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 32'd1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = fin ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (fin) begin
          state_next = S_IDLE;
        end else if (op_r == OP_SAMPLE &&
                     (hit_nonreg || (scan_end && (found_reg || hit_reg)))) begin
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD: state_next = S_CNT_WR;
      S_CNT_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    tab_rd_en  = 1'b0;
    tab_wr_en  = 1'b0;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_bin    = '0;
    fin_count  = '0;
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        unique case (op_r)
          OP_DEFINE: begin
            fin = 1'b1;
            if (!id_ok || !kind_ok) begin
              fin_status = STAT_BAD_RANGE;
            end else if (bin_present[idb]) begin
              fin_status = STAT_DUP_BIN;
            end
          end
          OP_ADD: begin
            if (add_bad) begin
              fin        = 1'b1;
              fin_status = STAT_BAD_RANGE;
            end else if (fill == '0) begin
              fin       = 1'b1;
              tab_wr_en = 1'b1;
            end
          end
          OP_SAMPLE: begin
            if (fill == '0) begin
              fin        = 1'b1;
              fin_status = STAT_UNMAPPED;
            end
          end
          OP_CLEAR: fin = 1'b1;
          default:  fin = 1'b1;
        endcase
      end
      S_SCAN: begin
        tab_rd_en = !all_issued;
        if (op_r == OP_ADD) begin
          if (overlap) begin
            fin        = 1'b1;
            fin_status = STAT_OVERLAP;
          end else if (scan_end) begin
            fin = 1'b1;
            if (tab_full) begin
              fin_status = STAT_FULL;
            end else begin
              tab_wr_en = 1'b1;
            end
          end
        end else if (scan_end && !hit_any && !found_reg) begin
          fin        = 1'b1;
          fin_status = STAT_UNMAPPED;
        end
      end
      S_CNT_RD: ;
      S_CNT_WR: begin
        fin     = 1'b1;
        fin_bin = hit_owner;
        if (bin_type[hb] == KIND_ILLEGAL) begin
          fin_status = STAT_ILL_HIT;
          fin_count  = cnt_cur;
        end else begin
          fin_status = (bin_type[hb] == KIND_REGULAR) ? STAT_REG_HIT : STAT_IGN_HIT;
          fin_count  = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      fill      <= '0;
      samples   <= '0;
      ndef      <= '0;
      nhit      <= '0;
      rd_valid  <= 1'b0;
      found_reg <= 1'b0;
      for (int i = 0; i < N_BINS; i++) begin
        bin_present[i] <= 1'b0;
        bin_nz[i]      <= 1'b0;
      end
    end else begin
      state    <= state_next;
      done     <= fin;
      rd_valid <= tab_rd_en;

      if (tab_wr_en) begin
        fill <= fill + FILL_W'(1);
      end

      // Execute step: define, clear, sample total
      if (state == S_EXEC) begin
        found_reg <= 1'b0;
        unique case (op_r)
          OP_DEFINE: begin
            if (id_ok && kind_ok && !bin_present[idb]) begin
              bin_present[idb] <= 1'b1;
              bin_nz[idb]      <= 1'b0;
              if (kind_r == KIND_REGULAR) begin
                ndef <= ndef + CNT_W'(1);
              end
            end
          end
          OP_SAMPLE: begin
            if (samples != COUNT_MAX) begin
              samples <= samples + 32'd1;
            end
          end
          OP_CLEAR: begin
            fill    <= '0;
            samples <= '0;
            ndef    <= '0;
            nhit    <= '0;
            for (int i = 0; i < N_BINS; i++) begin
              bin_present[i] <= 1'b0;
              bin_nz[i]      <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      // First regular match is kept; a non-regular match ends the scan
      if (state == S_SCAN && op_r == OP_SAMPLE && hit_reg && !found_reg) begin
        found_reg <= 1'b1;
      end

      // Count update of a regular or ignore hit
      if (state == S_CNT_WR && bin_type[hb] != KIND_ILLEGAL) begin
        bin_nz[hb] <= 1'b1;
        if (bin_type[hb] == KIND_REGULAR && !bin_nz[hb]) begin
          nhit <= nhit + CNT_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(op);
      value_r <= value;
      upper_r <= upper_bound;
      id_r    <= bin_id;
      kind_r  <= bin_kind;
    end

    if (state == S_EXEC) begin
      issue_idx <= '0;
    end else if (tab_rd_en) begin
      issue_idx <= issue_idx + FILL_W'(1);
    end

    if (state == S_EXEC && op_r == OP_DEFINE && id_ok && kind_ok && !bin_present[idb]) begin
      bin_type[idb] <= kind_t'(kind_r);
    end

    if (state == S_SCAN && (hit_nonreg || (hit_reg && !found_reg))) begin
      hit_owner <= ent.owner;
    end

    if (fin) begin
      status_r    <= fin_status;
      hit_bin_r   <= fin_bin;
      hit_count_r <= fin_count;
    end
  end

  // Bin count memory: registered read, write back of the incremented count
  always_ff @(posedge clk) begin
    if (state == S_CNT_RD) begin
      cnt_q <= cnt_mem[hb];
    end
    if (state == S_CNT_WR && bin_type[hb] != KIND_ILLEGAL) begin
      cnt_mem[hb] <= cnt_inc;
    end
  end

  assign status          = status_r;
  assign hit_bin         = hit_bin_r;
  assign hit_count       = hit_count_r;
  assign sample_total    = samples;
  assign regular_defined = 5'(ndef);
  assign regular_hit     = 5'(nhit);

endmodule

`default_nettype wire

// ===== sv/rbcc_range_tab.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbcc_range_tab import rbcc_pkg::*; #(
  parameter int DEPTH  = NUM_RANGES_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire range_ent_t        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output range_ent_t             rd_data
);

  range_ent_t mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rbcc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbcc_check import rbcc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [3:0]  status,
  input wire logic [3:0]  hit_bin,
  input wire logic [31:0] hit_count,
  input wire logic [4:0]  regular_defined,
  input wire logic [4:0]  regular_hit
);

  // An accepted transfer keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // A result ends a busy period
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished operation");

  // Only hits carry a bin and a count
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    done && !(status == STAT_REG_HIT || status == STAT_IGN_HIT ||
              status == STAT_ILL_HIT)
    |-> hit_bin == 4'd0 && hit_count == 32'd0)
    else $error("bin or count reported without a hit");

  // Hit regular bins never exceed defined regular bins
  a_cov_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> regular_hit <= regular_defined)
    else $error("regular_hit above regular_defined");

endmodule

bind range_bin_coverage_counter rbcc_check u_rbcc_check (.*);

`default_nettype wire

// ===== dv/range_bin_coverage_counter_test.sv =====
`timescale 1ns / 1ps

module range_bin_coverage_counter_test;
  import rbcc_pkg::*;

  // Kind code outside kind_t, must be rejected on define
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam logic [63:0] VAL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 900;

  typedef struct {
    op_t         op;
    logic [63:0] value;
    logic [63:0] upper;
    logic [3:0]  id;
    logic [1:0]  kind;
  } bin_cmd_t;

  typedef struct {
    status_t     status;
    logic [3:0]  bin;
    logic [31:0] count;
    logic [31:0] total;
    logic [4:0]  n_def;
    logic [4:0]  n_hit;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  op = OP_DEFINE;
  logic [63:0] value = '0;
  logic [63:0] upper_bound = '0;
  logic [3:0]  bin_id = '0;
  logic [1:0]  bin_kind = '0;
  logic        busy;
  logic        done;
  logic [3:0]  status;
  logic [3:0]  hit_bin;
  logic [31:0] hit_count;
  logic [31:0] sample_total;
  logic [4:0]  regular_defined;
  logic [4:0]  regular_hit;

  range_bin_coverage_counter DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .value           (value),
    .upper_bound     (upper_bound),
    .bin_id          (bin_id),
    .bin_kind        (bin_kind),
    .done            (done),
    .status          (status),
    .hit_bin         (hit_bin),
    .hit_count       (hit_count),
    .sample_total    (sample_total),
    .regular_defined (regular_defined),
    .regular_hit     (regular_hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the bin and range tables
  logic [63:0] tbl_lo    [NUM_RANGES_DEF];
  logic [63:0] tbl_hi    [NUM_RANGES_DEF];
  logic [3:0]  tbl_owner [NUM_RANGES_DEF];
  bit          tbl_used  [NUM_RANGES_DEF];
  int          tbl_fill;
  bit          bin_defined [N_BINS_DEF];
  kind_t       bin_kinds   [N_BINS_DEF];
  logic [31:0] bin_counts  [N_BINS_DEF];
  logic [31:0] sample_cnt;

  bin_cmd_t    cmd_queue[$];
  bin_result_t pending_results[$];
  bin_cmd_t    drv_cmd;
  int          accepted = 0;
  int          total_items = 0;
  int          errors = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  function automatic void clear_tables();
    for (int i = 0; i < NUM_RANGES_DEF; i++) begin
      tbl_lo[i] = '0;
      tbl_hi[i] = '0;
      tbl_owner[i] = '0;
      tbl_used[i] = 1'b0;
    end
    for (int b = 0; b < N_BINS_DEF; b++) begin
      bin_defined[b] = 1'b0;
      bin_kinds[b] = KIND_REGULAR;
      bin_counts[b] = '0;
    end
    tbl_fill = 0;
    sample_cnt = '0;
  endfunction

  // First stored range holding v among regular (or non-regular) bins, -1 if none
  function automatic int find_range(logic [63:0] v, bit want_regular);
    for (int i = 0; i < NUM_RANGES_DEF; i++) begin
      if (tbl_used[i] && bin_defined[tbl_owner[i]] &&
          ((bin_kinds[tbl_owner[i]] == KIND_REGULAR) == want_regular) &&
          v >= tbl_lo[i] && v <= tbl_hi[i])
        return i;
    end
    return -1;
  endfunction

  function automatic bin_result_t predict_bin_result(bin_cmd_t c);
    bin_result_t r;
    int          idx;
    bit          clash;
    logic [3:0]  b;
    r.status = STAT_OK;
    r.bin = '0;
    r.count = '0;
    r.n_def = '0;
    r.n_hit = '0;
    case (c.op)
      OP_DEFINE: begin
        if (c.kind > KIND_IGNORE) begin
          r.status = STAT_BAD_RANGE;
        end else if (bin_defined[c.id]) begin
          r.status = STAT_DUP_BIN;
        end else begin
          bin_defined[c.id] = 1'b1;
          bin_kinds[c.id] = kind_t'(c.kind);
          bin_counts[c.id] = '0;
        end
      end
      OP_ADD: begin
        if (!bin_defined[c.id] || c.value > c.upper) begin
          r.status = STAT_BAD_RANGE;
        end else begin
          clash = 1'b0;
          for (int i = 0; i < NUM_RANGES_DEF; i++)
            if (tbl_used[i] && tbl_owner[i] != c.id &&
                c.value <= tbl_hi[i] && tbl_lo[i] <= c.upper)
              clash = 1'b1;
          if (clash) begin
            r.status = STAT_OVERLAP;
          end else if (tbl_fill >= NUM_RANGES_DEF) begin
            r.status = STAT_FULL;
          end else begin
            tbl_lo[tbl_fill] = c.value;
            tbl_hi[tbl_fill] = c.upper;
            tbl_owner[tbl_fill] = c.id;
            tbl_used[tbl_fill] = 1'b1;
            tbl_fill++;
          end
        end
      end
      OP_SAMPLE: begin
        if (sample_cnt != COUNT_MAX) sample_cnt++;
        // illegal and ignore ranges take priority over regular ones
        idx = find_range(c.value, 1'b0);
        if (idx < 0) idx = find_range(c.value, 1'b1);
        if (idx < 0) begin
          r.status = STAT_UNMAPPED;
        end else begin
          b = tbl_owner[idx];
          if (bin_kinds[b] == KIND_ILLEGAL) begin
            r.status = STAT_ILL_HIT;
          end else begin
            if (bin_counts[b] != COUNT_MAX) bin_counts[b]++;
            r.status = (bin_kinds[b] == KIND_REGULAR) ? STAT_REG_HIT : STAT_IGN_HIT;
          end
          r.bin = b;
          r.count = bin_counts[b];
        end
      end
      default: clear_tables();
    endcase
    for (int i = 0; i < N_BINS_DEF; i++) begin
      if (bin_defined[i] && bin_kinds[i] == KIND_REGULAR) begin
        r.n_def++;
        if (bin_counts[i] != 0) r.n_hit++;
      end
    end
    r.total = sample_cnt;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_cmd(op_t o, logic [63:0] v, logic [63:0] u, logic [3:0] id,
                          logic [1:0] k);
    bin_cmd_t c;
    c.op = o;
    c.value = v;
    c.upper = u;
    c.id = id;
    c.kind = k;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    bit nxt_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        pending_results.insert(pending_results.size(), predict_bin_result(drv_cmd));
        accepted++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0) begin
          drv_cmd = cmd_queue.pop_front();
          op <= drv_cmd.op;
          value <= drv_cmd.value;
          upper_bound <= drv_cmd.upper;
          bin_id <= drv_cmd.id;
          bin_kind <= drv_cmd.kind;
          nxt_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: each done strobe is checked against the oldest prediction
  always @(posedge clk) begin
    bin_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, status);
        check_field("hit_bin", exp_r.bin, hit_bin);
        check_field("hit_count", exp_r.count, hit_count);
        check_field("sample_total", exp_r.total, sample_total);
        check_field("regular_defined", exp_r.n_def, regular_defined);
        check_field("regular_hit", exp_r.n_hit, regular_hit);
      end
    end
  end

  initial begin
    logic [63:0] base;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [3:0]  ep_bins[$];
    logic [1:0]  k;
    int          n;
    int          directed;
    clear_tables();

    // Directed: empty table, defines, bad-bin, reversed and overlap add-range rejects, each hit kind, clear
    push_cmd(OP_SAMPLE, 64'd5, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd15, KIND_ILLEGAL);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd7, KIND_IGNORE);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd3, KIND_BAD);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd0, KIND_ILLEGAL);
    push_cmd(OP_ADD, 64'd0, 64'd10, 4'd5, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd20, 64'd10, 4'd0, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd0, 64'd100, 4'd0, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd50, 64'd60, 4'd15, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd90, 64'd200, 4'd0, KIND_REGULAR);
    push_cmd(OP_ADD, VAL_MAX - 64'd15, VAL_MAX, 4'd15, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd300, 64'd400, 4'd7, KIND_REGULAR);
    push_cmd(OP_ADD, 64'd400, 64'd400, 4'd0, KIND_REGULAR);
    push_cmd(OP_ADD, VAL_MAX, VAL_MAX, 4'd7, KIND_REGULAR);
    push_cmd(OP_SAMPLE, 64'd0, VAL_MAX, 4'd15, KIND_BAD);
    push_cmd(OP_SAMPLE, 64'd95, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_SAMPLE, VAL_MAX, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_SAMPLE, 64'd400, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_SAMPLE, 64'd201, 64'd0, 4'd0, KIND_REGULAR);
    push_cmd(OP_DEFINE, 64'd0, 64'd0, 4'd1, KIND_REGULAR);
    push_cmd(OP_CLEAR, VAL_MAX, VAL_MAX, 4'd15, KIND_BAD);
    push_cmd(OP_SAMPLE, 64'd0, 64'd0, 4'd0, KIND_REGULAR);
    directed = cmd_queue.size();

    // Random episodes: mostly clear, define, fill ranges, then sample into them
    while (cmd_queue.size() < directed + RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0, 1: base = '0;
        2: base = rand64();
        default: base = VAL_MAX - 64'd1500;
      endcase
      if ($urandom_range(0, 3) != 0)
        push_cmd(OP_CLEAR, rand64(), rand64(), 4'($urandom), 2'($urandom));
      ep_bins.delete();
      n = $urandom_range(1, 12);
      repeat (n) begin
        ep_bins.insert(ep_bins.size(), 4'($urandom));
        k = ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
        push_cmd(OP_DEFINE, rand64(), rand64(), ep_bins[$], k);
      end
      n = $urandom_range(5, 45);
      repeat (n) begin
        lo = base + $urandom_range(0, 1500);
        hi = lo + $urandom_range(0, 60);
        if ($urandom_range(0, 15) == 0) hi = lo - 64'd1 - $urandom_range(0, 60);
        if ($urandom_range(0, 19) == 0) begin
          lo = rand64();
          hi = rand64();
        end
        push_cmd(OP_ADD, lo, hi,
                 ($urandom_range(0, 4) == 0) ? 4'($urandom) :
                 ep_bins[$urandom_range(0, ep_bins.size() - 1)],
                 2'($urandom));
      end
      n = $urandom_range(10, 60);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          push_cmd(op_t'($urandom_range(0, 3)), rand64(), rand64(), 4'($urandom),
                   2'($urandom));
        else
          push_cmd(OP_SAMPLE,
                   ($urandom_range(0, 9) == 0) ? rand64() : base + $urandom_range(0, 1600),
                   rand64(), 4'($urandom), 2'($urandom));
      end
    end
    total_items = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: all transfers accepted and all results back, then a quiet period
    while (accepted < total_items || pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rbcc_pkg.sv
sv/rbcc_range_tab.sv
sv/range_bin_coverage_counter.sv
sv/rbcc_check.sv
dv/range_bin_coverage_counter_test.sv
